FILE: rtl/aba_pkg.sv
// aba_pkg: op codes, widths and payload types of the affinity block allocator.
// No dependencies.
`timescale 1ns / 1ps
package aba_pkg;
    localparam logic [1:0] OP_BEGIN   = 2'd0;
    localparam logic [1:0] OP_MAP     = 2'd1;
    localparam logic [1:0] OP_ACQUIRE = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] stage;
        logic [5:0] sim_id;
        logic [9:0] scenario;
        logic [2:0] slot;
        logic       rec_scn;
    } t_req;

    typedef struct packed {
        logic [2:0] slot_out;
        logic       found;
        logic       scenario_loaded;
    } t_rsp;
endpackage

FILE: rtl/aba_req_if.sv
// aba_req_if / aba_rsp_if: valid-ready channels of the allocator.
// Depends on aba_pkg.
`timescale 1ns / 1ps
interface aba_req_if;
    logic           valid;
    logic           ready;
    aba_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aba_rsp_if;
    logic           valid;
    logic           ready;
    aba_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/aba_ram.sv
// aba_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module aba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/affinity_block_allocator.sv
// affinity_block_allocator: slot allocator with scenario affinity, top level.
// Depends on aba_pkg, aba_req_if/aba_rsp_if and aba_ram.
//
// channel  | dir | payload
// i_req    | in  | op, stage, sim_id, scenario, slot, rec_scn
// o_rsp    | out | slot_out, found, scenario_loaded
//
// After reset a clearing pass writes every scenario table entry, STAGES*8 entries
// (512), with i_req.ready low. Begin and release go straight to the response;
// map reads the table once per slot and stops at the first match; acquire tries
// the preferred slot first, else scans the slots, else walks the reservation
// list. All table reads go through one RAM port. The response waits in a
// register until taken; the next request is accepted after that.
`timescale 1ns / 1ps
module affinity_block_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aba_req_if.sink       i_req,
    aba_rsp_if.source     o_rsp
);
    localparam int SLOTS  = 8;
    localparam int STAGES = 64;
    localparam int SIMS   = 64;
    localparam int TDEPTH = STAGES * SLOTS;
    localparam int TAW    = $clog2(TDEPTH);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;  // issue read of slot r_idx
    localparam logic [3:0] ST_SCANW = 4'd3;  // check read data
    localparam logic [3:0] ST_PREF  = 4'd4;  // preferred slot read back
    localparam logic [3:0] ST_LIST  = 4'd5;  // issue reservation list read
    localparam logic [3:0] ST_LISTW = 4'd6;
    localparam logic [3:0] ST_LOAD  = 4'd7;  // read granted entry
    localparam logic [3:0] ST_LOADW = 4'd8;
    localparam logic [3:0] ST_RESP  = 4'd9;

    logic [3:0]        r_state, n_state;
    aba_pkg::t_req     r_req;
    logic [TAW-1:0]    r_clr;
    logic [3:0]        r_idx;        // slot scan index, holds SLOTS
    logic [6:0]        r_k;          // list walk index, holds SIMS
    logic [SLOTS-1:0]  r_lock;
    logic [SLOTS-1:0]  r_unres;
    logic [SIMS-1:0]   r_pref_v;
    logic [6:0]        r_count;
    logic              r_hit, r_second;
    logic [2:0]        r_got, r_second_slot;
    aba_pkg::t_rsp     r_rsp;
    logic              r_rsp_v;

    // scenario table: {valid, scenario}
    logic              t_we;
    logic [TAW-1:0]    t_addr;
    logic [10:0]       t_wdata, t_rdata;
    // preference: slot; reservation list: slot
    logic              p_we, l_we;
    logic [5:0]        p_addr, l_addr;
    logic [2:0]        p_wdata, p_rdata, l_rdata;

    aba_ram #(.WIDTH(11), .DEPTH(TDEPTH)) u_tbl (
        .i_clk, .i_we(t_we), .i_addr(t_addr), .i_wdata(t_wdata), .o_rdata(t_rdata));
    aba_ram #(.WIDTH(3), .DEPTH(SIMS)) u_pref (
        .i_clk, .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wdata),
        .o_rdata(p_rdata));
    aba_ram #(.WIDTH(3), .DEPTH(SIMS)) u_list (
        .i_clk, .i_we(l_we), .i_addr(l_addr), .i_wdata(r_got), .o_rdata(l_rdata));

    logic       accept;
    logic [2:0] idx3;
    logic       match, pref_ok, list_ok;

    assign accept  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE) && !r_rsp_v;
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data  = r_rsp;
    assign idx3    = r_idx[2:0];
    assign match   = t_rdata == {1'b1, r_req.scenario};
    // read the preference on the accepting edge so it is ready in ST_PREF
    assign p_addr  = (r_state == ST_IDLE) ? i_req.data.sim_id : r_req.sim_id;
    assign pref_ok = r_pref_v[r_req.sim_id] && !r_lock[p_rdata];
    assign list_ok = !r_lock[l_rdata];

    always_comb begin
        t_we    = 1'b0;
        t_addr  = {r_req.stage, idx3};
        t_wdata = {1'b1, r_req.scenario};
        p_we    = 1'b0;
        p_wdata = r_got;
        l_we    = 1'b0;
        l_addr  = r_k[5:0];
        unique case (r_state)
            ST_CLEAR: begin
                t_we    = 1'b1;
                t_addr  = r_clr;
                t_wdata = '0;
            end
            ST_LOAD, ST_LOADW: t_addr = {r_req.stage, r_got};
            ST_RESP: begin
                if (r_req.op == aba_pkg::OP_RELEASE && r_req.rec_scn) begin
                    t_we   = 1'b1;
                    t_addr = {r_req.stage, r_req.slot};
                end
                if (r_req.op == aba_pkg::OP_MAP && r_hit) begin
                    p_we   = 1'b1;
                    l_we   = r_count < 7'(SIMS);
                    l_addr = r_count[5:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == TAW'(TDEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_req.data.op)
                        aba_pkg::OP_MAP:     n_state = ST_SCAN;
                        aba_pkg::OP_ACQUIRE: n_state = ST_PREF;
                        default:             n_state = ST_RESP;
                    endcase
                end
            end
            ST_PREF:  n_state = pref_ok ? ST_LOAD : ST_SCAN;
            ST_SCAN:  n_state = ST_SCANW;
            ST_SCANW: begin
                if (r_req.op == aba_pkg::OP_MAP) begin
                    if (match || idx3 == 3'(SLOTS - 1)) n_state = ST_RESP;
                    else n_state = ST_SCAN;
                end else if (r_unres[idx3] && !r_lock[idx3] && !t_rdata[10]) begin
                    n_state = ST_LOAD;
                end else if (idx3 != 3'(SLOTS - 1)) begin
                    n_state = ST_SCAN;
                end else if (r_second || (r_unres[idx3] && !r_lock[idx3])) begin
                    n_state = ST_LOAD;
                end else begin
                    n_state = (r_count != 0) ? ST_LIST : ST_RESP;
                end
            end
            ST_LIST:  n_state = ST_LISTW;
            ST_LISTW: begin
                if (list_ok) n_state = ST_LOAD;
                else if (r_k + 7'd1 < r_count) n_state = ST_LIST;
                else n_state = ST_RESP;
            end
            ST_LOAD:  n_state = ST_LOADW;
            ST_LOADW: n_state = ST_RESP;
            ST_RESP:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_lock   <= '0;
            r_unres  <= '1;
            r_pref_v <= '0;
            r_count  <= '0;
            r_rsp_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req.data;
                        r_idx    <= '0;
                        r_k      <= '0;
                        r_hit    <= 1'b0;
                        r_got    <= '0;
                        r_second <= 1'b0;
                        r_rsp    <= '0;
                    end
                end
                ST_PREF: begin
                    if (pref_ok) begin
                        r_hit <= 1'b1;
                        r_got <= p_rdata;
                    end
                end
                ST_SCANW: begin
                    r_idx <= r_idx + 4'd1;
                    if (r_req.op == aba_pkg::OP_MAP) begin
                        if (match) begin
                            r_hit <= 1'b1;
                            r_got <= idx3;
                        end
                    end else if (r_unres[idx3] && !r_lock[idx3]) begin
                        if (!t_rdata[10]) begin
                            r_hit <= 1'b1;
                            r_got <= idx3;
                        end else if (!r_second) begin
                            r_second      <= 1'b1;
                            r_second_slot <= idx3;
                            if (idx3 == 3'(SLOTS - 1)) begin
                                r_hit <= 1'b1;
                                r_got <= idx3;
                            end
                        end else if (idx3 == 3'(SLOTS - 1)) begin
                            r_hit <= 1'b1;
                            r_got <= r_second_slot;
                        end
                    end else if (idx3 == 3'(SLOTS - 1) && r_second) begin
                        r_hit <= 1'b1;
                        r_got <= r_second_slot;
                    end
                end
                ST_LISTW: begin
                    r_k <= r_k + 7'd1;
                    if (list_ok) begin
                        r_hit <= 1'b1;
                        r_got <= l_rdata;
                    end
                end
                ST_LOADW: r_rsp.scenario_loaded <= match;
                ST_RESP: begin
                    r_rsp_v <= 1'b1;
                    unique case (r_req.op)
                        aba_pkg::OP_BEGIN: begin
                            r_pref_v <= '0;
                            r_unres  <= '1;
                            r_count  <= '0;
                        end
                        aba_pkg::OP_MAP: begin
                            r_pref_v[r_req.sim_id] <= r_hit;
                            if (r_hit) begin
                                r_unres[r_got] <= 1'b0;
                                if (r_count < 7'(SIMS)) r_count <= r_count + 7'd1;
                            end
                            r_rsp.found    <= r_hit;
                            r_rsp.slot_out <= r_got;
                        end
                        aba_pkg::OP_ACQUIRE: begin
                            if (r_hit) r_lock[r_got] <= 1'b1;
                            r_rsp.found    <= r_hit;
                            r_rsp.slot_out <= r_got;
                        end
                        aba_pkg::OP_RELEASE: r_lock[r_req.slot] <= 1'b0;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/aba_checker.sv
// aba_checker: port-level assertions for the allocator, bound to the top level.
// Depends on aba_pkg and affinity_block_allocator.
`timescale 1ns / 1ps
module aba_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          o_rsp_valid,
    input logic          o_rsp_ready,
    input aba_pkg::t_rsp o_rsp_data
);
    // no new request while a response is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !i_req_ready) else $error("request accepted with response pending");
    // a transfer in makes the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready) else $error("ready after transfer");
    a_loaded_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (!o_rsp_data.scenario_loaded || o_rsp_data.found))
        else $error("loaded without grant");
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_data.found) |-> o_rsp_data.slot_out == 3'd0)
        else $error("slot without grant");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp_data)))
        else $error("response dropped");
endmodule

bind affinity_block_allocator aba_checker u_aba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_data  (o_rsp.data)
);
